FILE: sv/sjd_pkg.sv
`timescale 1ns / 1ps

package sjd_pkg;

  localparam int NUMS_W     = 5;
  localparam int MASK_W     = 16;
  localparam int JOB_ID_W   = 32;
  localparam int SRV_W      = 4;
  localparam int ERR_W      = 3;
  localparam int IN_TDATA_W = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUTQ_DEPTH = 3;

  // Register select: paddr bit 2 picks the register.
  localparam logic REG_NUM_SERVERS = 1'b0;
  localparam logic REG_OFF_MASK    = 1'b1;

  typedef enum logic [1:0] {
    ACT_START,
    ACT_JOB,
    ACT_DONE,
    ACT_POWER
  } action_t;

  typedef enum logic [1:0] {
    KIND_DISPATCH,
    KIND_REQUEST,
    KIND_ERROR
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_UNREQUESTED,
    ERR_UNKNOWN_DONE,
    ERR_OFF_TO_OFF,
    ERR_ON_TO_BUSY,
    ERR_ON_TO_FREE,
    ERR_ALREADY_MARKED
  } err_t;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_BUSY,
    ST_OFF
  } srv_state_t;

  // Results of one executed transaction, handed from the core to the output queue.
  typedef struct packed {
    logic             disp;
    logic             req;
    logic             err;
    err_t             err_code;
    logic [SRV_W-1:0] target;
  } push_t;

endpackage

FILE: sv/sjd_cfg.sv
`timescale 1ns / 1ps

module sjd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sjd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sjd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sjd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [sjd_pkg::NUMS_W-1:0]     num_servers,
  output logic [sjd_pkg::MASK_W-1:0]     off_mask
);
  import sjd_pkg::*;

  logic [NUMS_W-1:0] num_servers_r;
  logic [MASK_W-1:0] off_mask_r;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_servers_r <= NUMS_W'(4);
      off_mask_r    <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_NUM_SERVERS: num_servers_r <= pwdata[NUMS_W-1:0];
        REG_OFF_MASK:    off_mask_r    <= pwdata[MASK_W-1:0];
        default:         num_servers_r <= num_servers_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NUM_SERVERS: prdata = CFG_DATA_W'(num_servers_r);
      REG_OFF_MASK:    prdata = CFG_DATA_W'(off_mask_r);
      default:         prdata = '0;
    endcase
  end

  assign num_servers = num_servers_r;
  assign off_mask    = off_mask_r;

endmodule

FILE: sv/sjd_core.sv
`timescale 1ns / 1ps

module sjd_core #(
  parameter int MAX_SERVERS = 16,
  parameter int JOB_BITS    = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  sjd_pkg::action_t             action,
  input  logic [sjd_pkg::JOB_ID_W-1:0] job_id,
  input  logic [sjd_pkg::SRV_W-1:0]    server,
  input  logic                         power_on,
  input  logic [sjd_pkg::NUMS_W-1:0]   num_servers,
  input  logic [sjd_pkg::MASK_W-1:0]   off_mask,
  output sjd_pkg::push_t               push,
  output logic [JOB_BITS-1:0]          job_number
);
  import sjd_pkg::*;

  logic [MAX_SERVERS-1:0][1:0] status_r, status_a, status_nxt;
  logic [MAX_SERVERS-1:0]      owd_r, owd_nxt;
  logic [JOB_BITS-1:0]         job_r [MAX_SERVERS];
  logic                        req_r, pend_r;
  logic                        req_a, pend_a;
  logic [JOB_BITS-1:0]         next_r;

  logic [MAX_SERVERS-1:0] inuse, free_c, match, hit_oh, sel, mask_ext, start_free;
  logic [MAX_SERVERS-1:0] free_a, disp_oh;
  logic [JOB_BITS-1:0]    job_cmp;
  logic [1:0]             sel_st;
  logic                   sel_owd, sel_any, any_free_c, two_free_c, hit_owd;
  logic                   need_req, err_v, quiet, settle, disp;
  err_t                   err_code;
  logic [SRV_W-1:0]       target;

  assign job_cmp  = JOB_BITS'(job_id);
  assign mask_ext = MAX_SERVERS'(off_mask);

  // Per-server status decode and job match.
  always_comb begin
    sel_st  = '0;
    sel_owd = 1'b0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      inuse[i]      = (i < int'(num_servers));
      free_c[i]     = inuse[i] && (status_r[i] == ST_FREE);
      match[i]      = inuse[i] && (status_r[i] == ST_BUSY) && (job_r[i] == job_cmp);
      sel[i]        = inuse[i] && (int'(server) == i);
      start_free[i] = inuse[i] && !mask_ext[i];
      if (sel[i]) begin
        sel_st  = sel_st | status_r[i];
        sel_owd = sel_owd | owd_r[i];
      end
    end
  end

  assign hit_oh     = match & (~match + MAX_SERVERS'(1));
  assign hit_owd    = |(hit_oh & owd_r);
  assign sel_any    = |sel;
  assign any_free_c = |free_c;
  assign two_free_c = |(free_c & (free_c - MAX_SERVERS'(1)));

  // Effect of the action itself.
  always_comb begin
    status_a = status_r;
    owd_nxt  = owd_r;
    req_a    = req_r;
    pend_a   = pend_r;
    need_req = 1'b0;
    err_v    = 1'b0;
    err_code = ERR_UNREQUESTED;
    quiet    = 1'b0;
    case (action)
      ACT_START: begin
        for (int i = 0; i < MAX_SERVERS; i++) begin
          if (inuse[i]) begin
            status_a[i] = mask_ext[i] ? ST_OFF : ST_FREE;
          end
        end
        owd_nxt  = '0;
        req_a    = 1'b0;
        pend_a   = 1'b0;
        need_req = |start_free;
      end
      ACT_JOB: begin
        if (!req_r) begin
          err_v    = 1'b1;
          err_code = ERR_UNREQUESTED;
        end else begin
          req_a    = 1'b0;
          pend_a   = 1'b1;
          need_req = two_free_c;
        end
      end
      ACT_DONE: begin
        if (!(|match)) begin
          err_v    = 1'b1;
          err_code = ERR_UNKNOWN_DONE;
        end else begin
          for (int i = 0; i < MAX_SERVERS; i++) begin
            if (hit_oh[i]) begin
              status_a[i] = owd_r[i] ? ST_OFF : ST_FREE;
              owd_nxt[i]  = 1'b0;
            end
          end
          need_req = !req_r && (hit_owd ? any_free_c : 1'b1);
        end
      end
      ACT_POWER: begin
        if (!sel_any) begin
          quiet = 1'b1;
        end else if (!power_on && sel_st == ST_OFF) begin
          err_v    = 1'b1;
          err_code = ERR_OFF_TO_OFF;
        end else if (power_on && sel_st == ST_BUSY) begin
          err_v    = 1'b1;
          err_code = ERR_ON_TO_BUSY;
        end else if (power_on && sel_st == ST_FREE) begin
          err_v    = 1'b1;
          err_code = ERR_ON_TO_FREE;
        end else if (!power_on && sel_st == ST_FREE) begin
          for (int i = 0; i < MAX_SERVERS; i++) begin
            if (sel[i]) status_a[i] = ST_OFF;
          end
        end else if (power_on) begin
          for (int i = 0; i < MAX_SERVERS; i++) begin
            if (sel[i]) status_a[i] = ST_FREE;
          end
          need_req = pend_r ? any_free_c : !req_r;
        end else if (sel_owd) begin
          err_v    = 1'b1;
          err_code = ERR_ALREADY_MARKED;
        end else begin
          owd_nxt = owd_r | sel;
        end
      end
      default: quiet = 1'b1;
    endcase
  end

  // Settle the pending job onto the lowest free server.
  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      free_a[i] = inuse[i] && (status_a[i] == ST_FREE);
    end
    disp_oh = pend_a ? (free_a & (~free_a + MAX_SERVERS'(1))) : '0;
    target  = '0;
    status_nxt = status_a;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      if (disp_oh[i]) begin
        target        = SRV_W'(i);
        status_nxt[i] = ST_BUSY;
      end
    end
  end

  assign settle = go && !err_v && !quiet;
  assign disp   = |disp_oh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      owd_r    <= '0;
      req_r    <= 1'b0;
      pend_r   <= 1'b0;
      next_r   <= '0;
    end else if (settle) begin
      status_r <= status_nxt;
      owd_r    <= owd_nxt;
      req_r    <= req_a | need_req;
      pend_r   <= pend_a & !disp;
      if (disp) next_r <= next_r + JOB_BITS'(1);
    end
  end

  // Job store: written only on dispatch, so no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      if (settle && disp_oh[i]) job_r[i] <= next_r;
    end
  end

  assign push.disp     = settle && disp;
  assign push.req      = settle && need_req;
  assign push.err      = go && err_v;
  assign push.err_code = err_code;
  assign push.target   = target;
  assign job_number    = next_r;

`ifndef SYNTHESIS
  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    push.disp |=> next_r == $past(next_r) + JOB_BITS'(1))
    else $error("job number did not advance on dispatch");

  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    push.err |=> $stable(status_r) && $stable(owd_r) && $stable(req_r) && $stable(pend_r))
    else $error("error transaction changed server state");

  a_req_sets: assert property (@(posedge clk) disable iff (!rst_n)
    push.req |=> req_r)
    else $error("request issued but not marked outstanding");

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    push.err |-> !push.disp && !push.req)
    else $error("error result mixed with dispatch or request");
`endif

endmodule

FILE: sv/sjd_outq.sv
`timescale 1ns / 1ps

module sjd_outq #(
  parameter int JOB_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sjd_pkg::push_t            push,
  input  logic [JOB_BITS-1:0]       job_number,
  output logic                      room,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sjd_pkg::kind_t            out_kind,
  output logic [sjd_pkg::SRV_W-1:0] out_target,
  output logic [JOB_BITS-1:0]       out_job,
  output sjd_pkg::err_t             out_err,
  output logic                      out_last
);
  import sjd_pkg::*;

  typedef struct packed {
    kind_t               kind;
    logic [SRV_W-1:0]    target;
    logic [JOB_BITS-1:0] job;
    err_t                err;
    logic                last;
  } ent_t;

  ent_t       ent_r [OUTQ_DEPTH];
  ent_t       ent_nxt [OUTQ_DEPTH];
  ent_t       e0, e1;
  logic [1:0] cnt_r, cnt_nxt, base, n_push;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & out_ready;
  assign room      = (cnt_r <= 2'd1);
  assign base      = cnt_r - 2'(pop);

  // Build up to two new entries: an error, a dispatch, a request, or dispatch then request.
  always_comb begin
    e0     = '{kind: KIND_REQUEST, target: '0, job: '0, err: ERR_UNREQUESTED, last: 1'b1};
    e1     = e0;
    n_push = 2'd0;
    if (push.err) begin
      e0.kind = KIND_ERROR;
      e0.err  = push.err_code;
      n_push  = 2'd1;
    end else if (push.disp) begin
      e0.kind   = KIND_DISPATCH;
      e0.target = push.target;
      e0.job    = job_number;
      e0.last   = !push.req;
      n_push    = push.req ? 2'd2 : 2'd1;
    end else if (push.req) begin
      n_push = 2'd1;
    end
  end

  // Shift toward the head on pop, append behind the survivors.
  always_comb begin
    for (int k = 0; k < OUTQ_DEPTH; k++) begin
      ent_nxt[k] = (pop && k < OUTQ_DEPTH - 1) ? ent_r[k + 1] : ent_r[k];
      if (n_push != 2'd0 && int'(base) == k) ent_nxt[k] = e0;
      if (n_push == 2'd2 && int'(base) + 1 == k) ent_nxt[k] = e1;
    end
  end

  assign cnt_nxt = base + n_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < OUTQ_DEPTH; k++) begin
      ent_r[k] <= ent_nxt[k];
    end
  end

  assign out_kind   = ent_r[0].kind;
  assign out_target = ent_r[0].target;
  assign out_job    = ent_r[0].job;
  assign out_err    = ent_r[0].err;
  assign out_last   = ent_r[0].last;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> room)
    else $error("result queue pushed without room");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DISPATCH && !out_last) |-> cnt_r >= 2'd2)
    else $error("dispatch without its trailing request");

  a_request_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DISPATCH) |-> out_last)
    else $error("request or error not marked last");
`endif

endmodule

FILE: sv/server_job_dispatcher.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+------------------------------------------
// in_      | in  | in_tvalid / in_tready   | tuser action, tdata job_id/server/power_on
// out_     | out | out_tvalid / out_tready | tuser kind, tdata target/job/err, tlast
// cfg_     | in  | APB, pready always high | num_servers @0x0, initial_off_mask @0x4
//
// An accepted transaction is held in the input register and executes from it (priority
// search over the server row) once the result queue has room; its results are registered
// into a 3-entry result queue, whose head drives out_tvalid.
// Throughput: one transaction per cycle while each yields at most one result and
// out_tready stays high; a dispatch plus request queues two entries, drained in turn.
// Execution waits while more than one result is queued; in_tready decodes from
// registers only, with no path from out_tready.
// rst_n is synchronous: all servers free, marks and flags clear, job number zero.

module server_job_dispatcher #(
  parameter int MAX_SERVERS = 16,
  parameter int JOB_BITS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] job_id, [35:32] server, [36] power_on, [39:37] zero
  input  logic [sjd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] action
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] target_server, [JOB_BITS+3:4] job_number, next 3 bits error_code, zero pad
  output logic [((sjd_pkg::SRV_W + JOB_BITS + sjd_pkg::ERR_W + 7) / 8) * 8 - 1:0] out_tdata,
  // [1:0] kind
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sjd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sjd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sjd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import sjd_pkg::*;

  localparam int OUT_TDATA_W = ((SRV_W + JOB_BITS + ERR_W + 7) / 8) * 8;

  // Input register.
  logic                in_v_r;
  action_t             action_r;
  logic [JOB_ID_W-1:0] job_id_r;
  logic [SRV_W-1:0]    server_r;
  logic                power_on_r;

  logic                go, room;
  logic [NUMS_W-1:0]   num_servers;
  logic [MASK_W-1:0]   off_mask;
  push_t               push;
  logic [JOB_BITS-1:0] job_number;

  kind_t               q_kind;
  logic [SRV_W-1:0]    q_target;
  logic [JOB_BITS-1:0] q_job;
  err_t                q_err;

  // Execute the held transaction whenever the result queue can take two entries.
  assign go        = in_v_r & room;
  assign in_tready = !in_v_r | room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // Hold payload until the held transaction executes.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      action_r   <= action_t'(in_tuser);
      job_id_r   <= in_tdata[JOB_ID_W-1:0];
      server_r   <= in_tdata[JOB_ID_W +: SRV_W];
      power_on_r <= in_tdata[JOB_ID_W + SRV_W];
    end
  end

  sjd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .num_servers (num_servers),
    .off_mask    (off_mask)
  );

  sjd_core #(
    .MAX_SERVERS (MAX_SERVERS),
    .JOB_BITS    (JOB_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .action      (action_r),
    .job_id      (job_id_r),
    .server      (server_r),
    .power_on    (power_on_r),
    .num_servers (num_servers),
    .off_mask    (off_mask),
    .push        (push),
    .job_number  (job_number)
  );

  sjd_outq #(
    .JOB_BITS (JOB_BITS)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .job_number (job_number),
    .room       (room),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (q_kind),
    .out_target (q_target),
    .out_job    (q_job),
    .out_err    (q_err),
    .out_last   (out_tlast)
  );

  // Pack fields lowest first, zero fill to whole bytes.
  assign out_tdata = OUT_TDATA_W'({q_err, q_job, q_target});
  assign out_tuser = q_kind;

endmodule
